// ===== hdl/ray_box_slab_intersection_macros.svh =====
// Assertion macros for the ray/box slab intersection block.
// Used by the port checker; no other dependencies.
`ifndef RAY_BOX_SLAB_INTERSECTION_MACROS_SVH
`define RAY_BOX_SLAB_INTERSECTION_MACROS_SVH

// check cons in the same cycle as ante
`define RBSI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// check cons in the cycle after ante
`define RBSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/rbsi_pkg.sv =====
// Package for the ray/box slab intersection block: beat types, formats, queue sizing.
// No dependencies.
`default_nettype none

package rbsi_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int DIR_FRAC    = 14;
  localparam int RECIP_SHIFT = DIR_FRAC + FRAC_BITS;
  localparam int NDIV        = RECIP_SHIFT + 1;
  localparam int QDEPTH      = 4;
  localparam int QAW         = $clog2(QDEPTH);

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] t_near;
    logic signed [31:0] t_far;
  } out_t;

  typedef struct packed {
    logic signed [32:0] dlo;
    logic signed [32:0] dhi;
    logic signed [31:0] inv;
  } axis_t;

  typedef axis_t [2:0] qitem_t;

endpackage

`default_nettype wire

// ===== hdl/rbsi_front.sv =====
// Front part: capture a ray/box beat, form plane distances and per-axis reciprocals
// through a bit-per-stage divider pipeline. Depends on rbsi_pkg.
`default_nettype none

module rbsi_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire logic            in_valid,
  input  wire rbsi_pkg::in_t   in_data,
  output logic                 fr_valid,
  output rbsi_pkg::qitem_t     fr_item
);

  typedef struct packed {
    logic signed [32:0] dlo;
    logic signed [32:0] dhi;
    logic [15:0]        mag;
    logic               neg;
    logic               zero;
    logic [15:0]        rem;
    logic [30:0]        quo;
  } lane_t;

  typedef lane_t [2:0] lanes_t;

  lanes_t                    st_r [rbsi_pkg::NDIV+1];
  logic [rbsi_pkg::NDIV:0]   vld_r;

  function automatic lane_t capture(logic signed [31:0] org, logic signed [15:0] d,
                                    logic signed [31:0] lo, logic signed [31:0] hi);
    lane_t l;
    l.dlo  = 33'(lo) - 33'(org);
    l.dhi  = 33'(hi) - 33'(org);
    l.neg  = d[15];
    l.mag  = d[15] ? 16'(-d) : 16'(d);
    l.zero = (d == 16'sd0);
    l.rem  = '0;
    l.quo  = '0;
    return l;
  endfunction

  function automatic lane_t div_step(lane_t a, logic b);
    lane_t      l;
    logic [16:0] t;
    l = a;
    t = {a.rem, b};
    if (t >= {1'b0, a.mag}) begin
      l.rem = 16'(t - {1'b0, a.mag});
      l.quo = {a.quo[29:0], 1'b1};
    end else begin
      l.rem = t[15:0];
      l.quo = {a.quo[29:0], 1'b0};
    end
    return l;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[rbsi_pkg::NDIV-1:0], in_valid};
    end
    if (adv) begin
      st_r[0][0] <= capture(in_data.origin_x, in_data.dir_x, in_data.box_min_x,
                            in_data.box_max_x);
      st_r[0][1] <= capture(in_data.origin_y, in_data.dir_y, in_data.box_min_y,
                            in_data.box_max_y);
      st_r[0][2] <= capture(in_data.origin_z, in_data.dir_z, in_data.box_min_z,
                            in_data.box_max_z);
      for (int k = 1; k <= rbsi_pkg::NDIV; k++) begin
        for (int a = 0; a < 3; a++) begin
          st_r[k][a] <= div_step(st_r[k-1][a], (k == 1));
        end
      end
    end
  end

  always_comb begin
    fr_valid = vld_r[rbsi_pkg::NDIV];
    for (int a = 0; a < 3; a++) begin
      fr_item[a].dlo = st_r[rbsi_pkg::NDIV][a].dlo;
      fr_item[a].dhi = st_r[rbsi_pkg::NDIV][a].dhi;
      if (st_r[rbsi_pkg::NDIV][a].zero) begin
        fr_item[a].inv = 32'sh7FFFFFFF;
      end else if (st_r[rbsi_pkg::NDIV][a].neg) begin
        fr_item[a].inv = -$signed({1'b0, st_r[rbsi_pkg::NDIV][a].quo});
      end else begin
        fr_item[a].inv = $signed({1'b0, st_r[rbsi_pkg::NDIV][a].quo});
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rbsi_queue.sv =====
// Short queue between front and back parts. Depends on rbsi_pkg.
`default_nettype none

module rbsi_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire rbsi_pkg::qitem_t push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  q_valid,
  output rbsi_pkg::qitem_t      q_data
);

  rbsi_pkg::qitem_t             mem [rbsi_pkg::QDEPTH];
  logic [rbsi_pkg::QAW-1:0]     wr_r, rd_r;
  logic [rbsi_pkg::QAW:0]       cnt_r;

  assign full    = (cnt_r == (rbsi_pkg::QAW+1)'(rbsi_pkg::QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_data  = mem[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop && q_valid) rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (rbsi_pkg::QAW+1)'(push) - (rbsi_pkg::QAW+1)'(pop && q_valid);
    end
    if (push) mem[wr_r] <= push_data;
  end

endmodule

`default_nettype wire

// ===== hdl/rbsi_back.sv =====
// Back part: scale plane distances, saturate, per-axis min/max, reduce, output register.
// Depends on rbsi_pkg.
`default_nettype none

module rbsi_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  input  wire rbsi_pkg::qitem_t q_data,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output rbsi_pkg::out_t        out_data
);

  logic signed [48:0] plo_r [6];
  logic signed [48:0] phi_r [6];
  logic signed [31:0] t_r   [6];
  logic signed [31:0] mn_r  [3];
  logic signed [31:0] mx_r  [3];
  logic [2:0]         v_r;
  logic               ov_r;
  rbsi_pkg::out_t     od_r;
  logic               adv;
  logic signed [31:0] near_c, far_c;

  function automatic logic signed [31:0] sat32(logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
    else if (v < -66'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [31:0] scale(logic signed [48:0] hi, logic signed [48:0] lo);
    logic signed [65:0] s;
    s = ($signed({{17{hi[48]}}, hi}) <<< rbsi_pkg::FRAC_BITS) + $signed({{17{lo[48]}}, lo});
    return sat32(s >>> rbsi_pkg::FRAC_BITS);
  endfunction

  assign adv       = !ov_r || out_ready;
  assign pop       = adv;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    near_c = mn_r[0];
    far_c  = mx_r[0];
    for (int a = 1; a < 3; a++) begin
      if (mn_r[a] > near_c) near_c = mn_r[a];
      if (mx_r[a] < far_c)  far_c  = mx_r[a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      ov_r <= 1'b0;
    end else if (adv) begin
      v_r  <= {v_r[1:0], q_valid};
      ov_r <= v_r[2];
    end
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        plo_r[2*a]   <= $signed({1'b0, q_data[a].dlo[15:0]}) * q_data[a].inv;
        phi_r[2*a]   <= $signed(q_data[a].dlo[32:16]) * q_data[a].inv;
        plo_r[2*a+1] <= $signed({1'b0, q_data[a].dhi[15:0]}) * q_data[a].inv;
        phi_r[2*a+1] <= $signed(q_data[a].dhi[32:16]) * q_data[a].inv;
      end
      for (int p = 0; p < 6; p++) begin
        t_r[p] <= scale(phi_r[p], plo_r[p]);
      end
      for (int a = 0; a < 3; a++) begin
        mn_r[a] <= (t_r[2*a] < t_r[2*a+1]) ? t_r[2*a] : t_r[2*a+1];
        mx_r[a] <= (t_r[2*a] < t_r[2*a+1]) ? t_r[2*a+1] : t_r[2*a];
      end
      od_r.t_near <= near_c;
      od_r.t_far  <= far_c;
      od_r.hit    <= (near_c <= far_c) && (far_c > 32'sd0);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ray_box_slab_intersection.sv =====
// Top level of the ray/box slab intersection block.
// Depends on rbsi_pkg, rbsi_front, rbsi_queue, rbsi_back.
//
//   channel  direction  handshake               payload
//   in_      input      in_valid / in_ready     rbsi_pkg::in_t
//   out_     output     out_valid / out_ready   rbsi_pkg::out_t
//
// One beat per cycle sustained while out_ready stays high; a taken input beat passes capture,
// 31 divider stages, the queue and 4 back stages before out_valid rises.
// The reciprocal divider pipeline sets the latency, one quotient bit per stage.
// Reset is synchronous; no clearing pass.
// in_ready drops while the 4-entry queue is full; the back part stalls on out_ready alone.
`default_nettype none

module ray_box_slab_intersection (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire rbsi_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output rbsi_pkg::out_t      out_data
);

  logic             q_full, fr_valid, q_valid, pop;
  rbsi_pkg::qitem_t fr_item, q_data;

  assign in_ready = !q_full;

  rbsi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (!q_full),
    .in_valid (in_valid),
    .in_data  (in_data),
    .fr_valid (fr_valid),
    .fr_item  (fr_item)
  );

  rbsi_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fr_valid && !q_full),
    .push_data (fr_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  rbsi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== hdl/rbsi_checker.sv =====
// Port checker for the ray/box slab intersection block, bound to the top level.
// Depends on rbsi_pkg and ray_box_slab_intersection_macros.svh.
`default_nettype none
`include "ray_box_slab_intersection_macros.svh"

module rbsi_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire rbsi_pkg::out_t out_data
);

  `RBSI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "out_valid dropped")
  `RBSI_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "out beat changed")
  `RBSI_ASSERT_NOW(a_hit_order, out_valid && out_data.hit, out_data.t_near <= out_data.t_far, "hit with near past far")
  `RBSI_ASSERT_NOW(a_hit_ahead, out_valid && out_data.hit, out_data.t_far > 32'sd0, "hit behind origin")

endmodule

bind ray_box_slab_intersection rbsi_checker u_rbsi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== verif/tb_ray_box_slab_intersection.sv =====
// Testbench for ray_box_slab_intersection: directed table of ray/box beats, then random
// rays, checked against a slab-test predictor. Depends on rbsi_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_ray_box_slab_intersection;

  localparam int          NUM_RANDOM = 1530;
  localparam int          IDLE_PCT   = 37;
  localparam int          STALL_LIM  = 20000;
  localparam logic signed [31:0] QMAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] QMIN = 32'sh80000000;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  rbsi_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  rbsi_pkg::out_t out_data;

  rbsi_pkg::out_t slab_expected[$];
  int   error_count;
  bit   sending_done;
  bit   calm_phase;
  bit   hold_sink;
  int   sink_hold_cycles;
  int   idle_cycles;

  typedef struct {
    rbsi_pkg::in_t  ray;
    bit             known;
    rbsi_pkg::out_t result;
  } dir_row_t;

  dir_row_t dir_rows[$];

  ray_box_slab_intersection dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint clamp32(longint v);
    if (v > longint'(QMAX)) return longint'(QMAX);
    if (v < longint'(QMIN)) return longint'(QMIN);
    return v;
  endfunction

  function automatic longint slab_recip(logic signed [15:0] d);
    longint num;
    num = longint'(1) << rbsi_pkg::RECIP_SHIFT;
    if (d == 16'sd0) return longint'(QMAX);
    return clamp32(num / longint'(d));
  endfunction

  function automatic longint plane_time(logic signed [31:0] plane, logic signed [31:0] org,
                                        longint inv);
    longint diff;
    longint prod;
    diff = longint'(plane) - longint'(org);
    prod = diff * inv;
    return clamp32(prod >>> rbsi_pkg::FRAC_BITS);
  endfunction

  function automatic rbsi_pkg::out_t slab_hit(rbsi_pkg::in_t r);
    logic signed [31:0] org[3];
    logic signed [31:0] lo[3];
    logic signed [31:0] hi[3];
    logic signed [15:0] dv[3];
    longint tn;
    longint tf;
    longint inv;
    longint t1;
    longint t2;
    rbsi_pkg::out_t res;
    org = '{r.origin_x, r.origin_y, r.origin_z};
    lo  = '{r.box_min_x, r.box_min_y, r.box_min_z};
    hi  = '{r.box_max_x, r.box_max_y, r.box_max_z};
    dv  = '{r.dir_x, r.dir_y, r.dir_z};
    tn = longint'(QMIN);
    tf = longint'(QMAX);
    for (int a = 0; a < 3; a++) begin
      inv = slab_recip(dv[a]);
      t1 = plane_time(lo[a], org[a], inv);
      t2 = plane_time(hi[a], org[a], inv);
      if (t1 < t2) begin
        if (t1 > tn) tn = t1;
        if (t2 < tf) tf = t2;
      end else begin
        if (t2 > tn) tn = t2;
        if (t1 < tf) tf = t1;
      end
    end
    res.hit    = (tn <= tf) && (tf > 0);
    res.t_near = tn[31:0];
    res.t_far  = tf[31:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic rbsi_pkg::in_t make_ray(int o, int d, int lo, int hi);
    rbsi_pkg::in_t r;
    r.origin_x = o;  r.origin_y = o;  r.origin_z = o;
    r.dir_x = d[15:0];  r.dir_y = d[15:0];  r.dir_z = d[15:0];
    r.box_min_x = lo;  r.box_min_y = lo;  r.box_min_z = lo;
    r.box_max_x = hi;  r.box_max_y = hi;  r.box_max_z = hi;
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0:       return $urandom();
      1:       return QMAX;
      2:       return QMIN;
      default: return $signed($urandom_range(0, 32'h00200000)) - 32'sh00100000;
    endcase
  endfunction

  function automatic logic [15:0] rand_dir();
    case ($urandom_range(0, 6))
      0:       return 16'h0000;
      1:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      2:       return $urandom_range(0, 1) ? 16'h0001 : 16'hFFFF;
      3:       return 16'($urandom());
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic rbsi_pkg::in_t rand_ray();
    rbsi_pkg::in_t r;
    logic signed [31:0] c;
    logic signed [31:0] h;
    r.origin_x = rand_coord();  r.origin_y = rand_coord();  r.origin_z = rand_coord();
    r.dir_x = rand_dir();  r.dir_y = rand_dir();  r.dir_z = rand_dir();
    if ($urandom_range(0, 3) == 0) begin
      r.box_min_x = rand_coord();  r.box_min_y = rand_coord();  r.box_min_z = rand_coord();
      r.box_max_x = rand_coord();  r.box_max_y = rand_coord();  r.box_max_z = rand_coord();
    end else begin
      c = $signed($urandom_range(0, 32'h00400000)) - 32'sh00200000;
      h = $urandom_range(0, 32'h00080000);
      r.box_min_x = c - h;  r.box_max_x = c + h;
      c = $signed($urandom_range(0, 32'h00400000)) - 32'sh00200000;
      r.box_min_y = c - h;  r.box_max_y = c + h;
      c = $signed($urandom_range(0, 32'h00400000)) - 32'sh00200000;
      r.box_min_z = c - h;  r.box_max_z = c + h;
    end
    return r;
  endfunction

  task automatic send_ray(rbsi_pkg::in_t r);
    while (!calm_phase && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    slab_expected = {slab_expected, slab_hit(r)};
  endtask

  initial begin
    dir_row_t row;
    rbsi_pkg::out_t chk;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    error_count = 0;
    sending_done = 1'b0;
    calm_phase = 1'b0;
    hold_sink = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    row.known = 1'b1;
    row.ray = make_ray(0, 16'h4000, 32'sh00010000, 32'sh00020000);
    row.result = '{hit: 1'b1, t_near: 32'sh00010000, t_far: 32'sh00020000};
    dir_rows = {dir_rows, row};
    row.ray = make_ray(0, 16'h4000, -32'sh00020000, -32'sh00010000);
    row.result = '{hit: 1'b0, t_near: -32'sh00020000, t_far: -32'sh00010000};
    dir_rows = {dir_rows, row};
    row.ray = make_ray(0, 0, 0, 0);
    row.result = '{hit: 1'b0, t_near: 32'sh0, t_far: 32'sh0};
    dir_rows = {dir_rows, row};
    row.ray = make_ray(0, 0, -32'sh00010000, 32'sh00010000);
    row.result = '{hit: 1'b1, t_near: -32'sh7FFFFFFF, t_far: QMAX};
    dir_rows = {dir_rows, row};
    row.known = 1'b0;
    row.ray = make_ray(QMIN, 16'h7FFF, QMAX, QMAX);  dir_rows = {dir_rows, row};
    row.ray = make_ray(QMAX, 16'h8000, QMIN, QMIN);  dir_rows = {dir_rows, row};
    row.ray = make_ray(QMAX, 16'h8000, QMIN, QMAX);  dir_rows = {dir_rows, row};
    row.ray = make_ray(0, 16'h0001, 32'sh00000001, 32'sh00010000);
    dir_rows = {dir_rows, row};
    row.ray = make_ray(0, 16'hFFFF, -32'sh00010000, 32'sh00010000);
    dir_rows = {dir_rows, row};
    row.ray = make_ray(0, 16'h4000, 32'sh00020000, 32'sh00010000);
    dir_rows = {dir_rows, row};
    row.ray = make_ray(0, 16'h1234, 32'sh00030000, 32'sh00050000);
    dir_rows = {dir_rows, row};
    row.ray = make_ray(32'sh00010000, 16'hC000, -32'sh7000, 32'sh00008000);
    dir_rows = {dir_rows, row};
    row.ray = make_ray(0, 0, QMIN, QMAX);  row.ray.dir_y = 16'h4000;
    dir_rows = {dir_rows, row};
    row.ray = make_ray(0, 16'h2000, -32'sh00010000, 32'sh0);  row.ray.dir_z = 0;
    dir_rows = {dir_rows, row};
    row.ray = make_ray(32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    dir_rows = {dir_rows, row};
    row.ray = make_ray(32'h55555555, 16'h5555, 32'hAAAAAAAA, 32'h55555555);
    dir_rows = {dir_rows, row};

    foreach (dir_rows[i]) begin
      if (dir_rows[i].known) begin
        chk = slab_hit(dir_rows[i].ray);
        if (chk !== dir_rows[i].result)
          report_mismatch($sformatf("table row %0d", i), chk.t_near,
                          dir_rows[i].result.t_near);
      end
      send_ray(dir_rows[i].ray);
    end

    // stall the sink long enough to fill the block and back up in_ready
    hold_sink = 1'b1;
    for (int i = 0; i < 60; i++) send_ray(rand_ray());
    in_valid <= 1'b0;
    wait (!hold_sink);

    // pause until every beat has drained
    while (slab_expected.size() != 0) @(posedge clk);
    @(posedge clk);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      calm_phase = (i >= 600 && i < 800);
      send_ray(rand_ray());
    end
    in_valid <= 1'b0;
    calm_phase = 1'b0;
    sending_done = 1'b1;
  end

  initial begin
    sink_hold_cycles = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        out_ready <= 1'b0;
        sink_hold_cycles++;
        if (sink_hold_cycles >= 300) hold_sink = 1'b0;
      end else begin
        out_ready <= calm_phase || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    rbsi_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (slab_expected.size() == 0) begin
        report_mismatch("unexpected beat", out_data.t_near, 32'h0);
      end else begin
        want = slab_expected.pop_front();
        if (out_data.hit !== want.hit)
          report_mismatch("hit", {31'b0, out_data.hit}, {31'b0, want.hit});
        if (out_data.t_near !== want.t_near)
          report_mismatch("t_near", out_data.t_near, want.t_near);
        if (out_data.t_far !== want.t_far)
          report_mismatch("t_far", out_data.t_far, want.t_far);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIM) begin
        $display("ray_box_slab_intersection test failed");
        $finish;
      end
      if (sending_done && slab_expected.size() == 0) begin
        repeat (80) @(posedge clk);
        if (error_count == 0 && slab_expected.size() == 0) begin
          $display("ray_box_slab_intersection test passed");
        end else begin
          $display("ray_box_slab_intersection test failed");
        end
        $finish;
      end
    end
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/rbsi_pkg.sv
hdl/rbsi_front.sv
hdl/rbsi_queue.sv
hdl/rbsi_back.sv
hdl/ray_box_slab_intersection.sv
hdl/rbsi_checker.sv
verif/tb_ray_box_slab_intersection.sv
